@@ hw/rtl/mtc_pkg.sv @@
// Package for the MIDI time code assembler: command and rate codes,
// field widths, the held time record and the result record.
// No dependencies.
`default_nettype none

package mtc_pkg;

  localparam int CMD_W      = 2;
  localparam int QF_W       = 7;
  localparam int BYTE_W     = 8;
  localparam int RATE_W     = 2;
  localparam int NIB_W      = 4;
  localparam int NIB_NUM_W  = 3;
  localparam int NIB_COUNT  = 8;
  localparam int TIMEOUT_W  = 16;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [CMD_W-1:0] CMD_QF   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FF   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

  localparam logic [RATE_W-1:0] RATE_24      = 2'd0;
  localparam logic [RATE_W-1:0] RATE_25      = 2'd1;
  localparam logic [RATE_W-1:0] RATE_30      = 2'd2;
  localparam logic [RATE_W-1:0] RATE_UNKNOWN = 2'd3;

  localparam logic [NIB_NUM_W-1:0] NIB_FIRST = 3'd0;
  localparam logic [NIB_NUM_W-1:0] NIB_LAST  = 3'd7;

  localparam logic [APB_ADDR_W-3:0] REG_TIMEOUT_TICKS = 1'd0;
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET     = 16'd1000;

  typedef struct packed {
    logic [BYTE_W-1:0] hour;
    logic [BYTE_W-1:0] minute;
    logic [BYTE_W-1:0] second;
    logic [BYTE_W-1:0] frame;
    logic [RATE_W-1:0] rate;
  } mtc_time_t;

  typedef struct packed {
    logic [BYTE_W-1:0] hour;
    logic [BYTE_W-1:0] minute;
    logic [BYTE_W-1:0] second;
    logic [BYTE_W-1:0] frame_count;
    logic [RATE_W-1:0] rate;
    logic              time_valid;
    logic              changed;
  } mtc_result_t;

endpackage

`default_nettype wire

@@ hw/rtl/mtc_item_if.sv @@
// Input channel of the MIDI time code assembler: valid/ready plus one item.
// Depends on mtc_pkg.
`default_nettype none

interface mtc_item_if
  import mtc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [QF_W-1:0]   qf_byte;
  logic [BYTE_W-1:0] ff_rate_byte;
  logic [BYTE_W-1:0] ff_hour;
  logic [BYTE_W-1:0] ff_minute;
  logic [BYTE_W-1:0] ff_second;
  logic [BYTE_W-1:0] ff_frame;

  modport source (
    output valid, cmd, qf_byte, ff_rate_byte, ff_hour, ff_minute, ff_second, ff_frame,
    input  ready
  );

  modport sink (
    input  valid, cmd, qf_byte, ff_rate_byte, ff_hour, ff_minute, ff_second, ff_frame,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/mtc_result_if.sv @@
// Result channel of the MIDI time code assembler: valid/ready plus one result.
// Depends on mtc_pkg.
`default_nettype none

interface mtc_result_if
  import mtc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] hour;
  logic [BYTE_W-1:0] minute;
  logic [BYTE_W-1:0] second;
  logic [BYTE_W-1:0] frame_count;
  logic [RATE_W-1:0] rate;
  logic              time_valid;
  logic              changed;

  modport source (
    output valid, hour, minute, second, frame_count, rate, time_valid, changed,
    input  ready
  );

  modport sink (
    input  valid, hour, minute, second, frame_count, rate, time_valid, changed,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/midi_timecode_assembler_top.sv @@
// Top level of the MIDI time code assembler: quarter frame, full frame and
// tick handling, timeout register on APB, result register with skid stage.
// Depends on mtc_pkg, mtc_item_if and mtc_result_if.
//
//   channel  | kind          | transaction
//   ---------+---------------+------------------------------------------
//   item     | valid/ready   | one command: quarter frame, full frame, tick
//   result   | valid/ready   | one time report per item
//   apb      | APB write/read| timeout_ticks at byte address 0
//
// One item per cycle while ready is high; its result is registered.
// All state updates in a single pass between the item and the result register.
// A skid stage holds one result while the result side stalls, so an item is
// still taken in that cycle; ready drops only while the skid stage is full.
// Reset is synchronous, active high, resets all state and empties both stages.
`default_nettype none

module midi_timecode_assembler_top
  import mtc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  mtc_item_if.sink                   item,
  mtc_result_if.source               result,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [TIMEOUT_W-1:0] timeout_ticks;
  logic [NIB_W-1:0]     store [NIB_COUNT];
  logic [NIB_NUM_W-1:0] prev_num;
  logic                 prev_none;
  logic                 first_seen;
  logic                 going_forward;
  logic                 is_moving;
  logic                 valid_flag;
  mtc_time_t            held_time;
  logic [TIMEOUT_W-1:0] timeout_left;

  logic [NIB_W-1:0]     store_next [NIB_COUNT];
  logic [NIB_NUM_W-1:0] prev_num_next;
  logic                 prev_none_next;
  logic                 first_seen_next;
  logic                 going_forward_next;
  logic                 is_moving_next;
  logic                 valid_flag_next;
  mtc_time_t            held_time_next;
  logic [TIMEOUT_W-1:0] timeout_left_next;
  logic                 changed_next;
  mtc_result_t          res_next;

  mtc_result_t out_reg;
  logic        out_valid;
  mtc_result_t skid;
  logic        skid_valid;

  logic accept;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite &&
                     (paddr[APB_ADDR_W-1:2] == REG_TIMEOUT_TICKS);
  assign prdata    = (paddr[APB_ADDR_W-1:2] == REG_TIMEOUT_TICKS) ?
                     {{(APB_DATA_W-TIMEOUT_W){1'b0}}, timeout_ticks} : '0;

  assign item.ready = !skid_valid;
  assign accept     = item.valid && item.ready;

  always_comb begin
    logic [NIB_NUM_W-1:0] num;
    logic [NIB_W-1:0]     val;
    logic [2:0]           code;
    logic [1:0]           ff_code;

    num     = item.qf_byte[6:4];
    val     = item.qf_byte[3:0];
    code    = 3'd0;
    ff_code = item.ff_rate_byte[6:5];

    store_next         = store;
    prev_num_next      = prev_num;
    prev_none_next     = prev_none;
    first_seen_next    = first_seen;
    going_forward_next = going_forward;
    is_moving_next     = is_moving;
    valid_flag_next    = valid_flag;
    held_time_next     = held_time;
    timeout_left_next  = timeout_left;
    changed_next       = 1'b0;

    unique case (item.cmd)
      CMD_QF: begin
        store_next[num] = val;
        if (num == NIB_FIRST && !first_seen) begin
          valid_flag_next = 1'b0;
          first_seen_next = 1'b1;
        end
        if (num == NIB_LAST && first_seen_next) begin
          valid_flag_next = 1'b1;
        end
        if (!prev_none) begin
          priority if (prev_num + 3'd1 == num) begin
            going_forward_next = 1'b1;
            is_moving_next     = 1'b1;
          end else if (num + 3'd1 == prev_num) begin
            going_forward_next = 1'b0;
            is_moving_next     = 1'b1;
          end else begin
            valid_flag_next     = 1'b0;
            first_seen_next     = (num == NIB_FIRST);
            held_time_next.rate = RATE_UNKNOWN;
            going_forward_next  = 1'b0;
            is_moving_next      = 1'b0;
          end
        end
        held_time_next.frame  = {3'd0, store_next[1][0], store_next[0]};
        held_time_next.second = {2'd0, store_next[3][1:0], store_next[2]};
        held_time_next.minute = {2'd0, store_next[5][1:0], store_next[4]};
        held_time_next.hour   = {3'd0, store_next[7][0], store_next[6]};
        code = store_next[7][3:1];
        priority case (code)
          3'd0:         held_time_next.rate = RATE_24;
          3'd1:         held_time_next.rate = RATE_25;
          3'd2, 3'd3:   held_time_next.rate = RATE_30;
          default:      held_time_next.rate = held_time_next.rate;
        endcase
        prev_num_next  = num;
        prev_none_next = 1'b0;
        if (valid_flag_next) begin
          timeout_left_next = timeout_ticks;
        end
        changed_next = valid_flag_next && is_moving_next &&
                       ((going_forward_next && num == NIB_LAST) ||
                        (!going_forward_next && num == NIB_FIRST));
      end
      CMD_FF: begin
        held_time_next.hour   = item.ff_hour;
        held_time_next.minute = item.ff_minute;
        held_time_next.second = item.ff_second;
        held_time_next.frame  = item.ff_frame;
        priority case (ff_code)
          2'd0:    held_time_next.rate = RATE_24;
          2'd1:    held_time_next.rate = RATE_25;
          default: held_time_next.rate = RATE_30;
        endcase
        valid_flag_next   = 1'b1;
        store_next[0]     = item.ff_frame[3:0];
        store_next[1]     = item.ff_frame[7:4];
        store_next[2]     = item.ff_second[3:0];
        store_next[3]     = item.ff_second[7:4];
        store_next[4]     = item.ff_minute[3:0];
        store_next[5]     = item.ff_minute[7:4];
        store_next[6]     = item.ff_hour[3:0];
        store_next[7]     = {1'b0, ff_code, item.ff_hour[4]};
        prev_none_next    = 1'b1;
        timeout_left_next = timeout_ticks;
        changed_next      = 1'b1;
      end
      CMD_TICK: begin
        if (valid_flag) begin
          if (timeout_left <= TIMEOUT_W'(1)) begin
            timeout_left_next = '0;
            valid_flag_next   = 1'b0;
            changed_next      = 1'b1;
          end else begin
            timeout_left_next = timeout_left - TIMEOUT_W'(1);
          end
        end
      end
      default: begin
        changed_next = 1'b0;
      end
    endcase

    if (valid_flag_next) begin
      res_next.hour        = held_time_next.hour;
      res_next.minute      = held_time_next.minute;
      res_next.second      = held_time_next.second;
      res_next.frame_count = held_time_next.frame;
      res_next.rate        = held_time_next.rate;
    end else begin
      res_next.hour        = '0;
      res_next.minute      = '0;
      res_next.second      = '0;
      res_next.frame_count = '0;
      res_next.rate        = RATE_UNKNOWN;
    end
    res_next.time_valid = valid_flag_next;
    res_next.changed    = changed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      timeout_ticks <= pwdata[TIMEOUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NIB_COUNT; i++) begin
        store[i] <= '0;
      end
      prev_num      <= '0;
      prev_none     <= 1'b1;
      first_seen    <= 1'b0;
      going_forward <= 1'b1;
      is_moving     <= 1'b0;
      valid_flag    <= 1'b0;
      held_time     <= '{hour: '0, minute: '0, second: '0, frame: '0, rate: RATE_UNKNOWN};
      timeout_left  <= '0;
    end else if (accept) begin
      store         <= store_next;
      prev_num      <= prev_num_next;
      prev_none     <= prev_none_next;
      first_seen    <= first_seen_next;
      going_forward <= going_forward_next;
      is_moving     <= is_moving_next;
      valid_flag    <= valid_flag_next;
      held_time     <= held_time_next;
      timeout_left  <= timeout_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || result.ready) begin
      if (skid_valid) begin
        out_reg <= skid;
      end else if (accept) begin
        out_reg <= res_next;
      end
    end else if (accept) begin
      skid <= res_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.hour        = out_reg.hour;
  assign result.minute      = out_reg.minute;
  assign result.second      = out_reg.second;
  assign result.frame_count = out_reg.frame_count;
  assign result.rate        = out_reg.rate;
  assign result.time_valid  = out_reg.time_valid;
  assign result.changed     = out_reg.changed;

endmodule

`default_nettype wire
